// ----- rtl/gcb_pkg.sv -----
// ----------------------------------------------------------------------------
// gcb_pkg: shared types, constants and helpers of the glyph coverage blender
// Register map, pipeline control struct, nibble weight and divide-by-63.
// ----------------------------------------------------------------------------
package gcb_pkg;

  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned ColorW  = 16;
  localparam int unsigned WeightW = 6;
  localparam int unsigned SumW    = 12;

  localparam logic [1:0] RegFgColor = 2'd0;
  localparam logic [1:0] RegBgColor = 2'd1;
  localparam logic [1:0] RegOpaque  = 2'd2;

  localparam logic [WeightW-1:0] WeightMax = 6'd63;
  localparam logic [3:0]         NibbleBg  = 4'hF;

  localparam logic [ColorW-1:0] FgReset = 16'hFFFF;
  localparam logic [ColorW-1:0] BgReset = 16'h0000;

  // per-stage load enables handed to the pixel lanes
  typedef struct packed {
    logic en2;
    logic en3;
  } pipe_en_t;

  // zero stays zero, otherwise (n+1)*4-1 = 4n+3
  function automatic logic [WeightW-1:0] nibble_weight(input logic [3:0] n);
    logic [WeightW-1:0] w;
    w = (n == 4'd0) ? '0 : {n, 2'b11};
    return w;
  endfunction

  // x / 63 for x < 4032: x = 64*q0 + lo gives x - 63*q0 = lo + q0 < 126,
  // so one compare-and-correct finishes the quotient
  function automatic logic [WeightW-1:0] div63(input logic [SumW-1:0] x);
    logic [WeightW-1:0] q0;
    logic [WeightW:0]   rem;
    logic [WeightW-1:0] q;
    q0  = x[SumW-1:WeightW];
    rem = {1'b0, x[WeightW-1:0]} + {1'b0, q0};
    q   = (rem >= {1'b0, WeightMax}) ? q0 + 6'd1 : q0;
    return q;
  endfunction

endpackage

// ----- rtl/gcb_pixel.sv -----
// ----------------------------------------------------------------------------
// gcb_pixel: one pixel lane of the blender
// Stage 2 forms the weighted channel sums, stage 3 divides by 63 and packs.
// ----------------------------------------------------------------------------
module gcb_pixel (
  input  logic                                clk_i,
  input  gcb_pkg::pipe_en_t                   en_i,
  input  logic [gcb_pkg::WeightW-1:0]         weight_i,
  input  logic [gcb_pkg::ColorW-1:0]          fg_i,
  input  logic [gcb_pkg::ColorW-1:0]          bg_i,
  output logic [gcb_pkg::ColorW-1:0]          pixel_o
);

  logic [gcb_pkg::WeightW-1:0] inv_w;
  logic [gcb_pkg::SumW-1:0]    sum_r_d, sum_g_d, sum_b_d;
  logic [gcb_pkg::SumW-1:0]    sum_r_q, sum_g_q, sum_b_q;
  logic [gcb_pkg::WeightW-1:0] q_r, q_g, q_b;
  logic [gcb_pkg::ColorW-1:0]  pixel_d, pixel_q;

  assign inv_w = gcb_pkg::WeightMax - weight_i;

  always_comb begin
    sum_r_d = {6'd0, 1'b0, fg_i[15:11]} * {6'd0, inv_w}
            + {6'd0, 1'b0, bg_i[15:11]} * {6'd0, weight_i};
    sum_g_d = {6'd0, fg_i[10:5]} * {6'd0, inv_w}
            + {6'd0, bg_i[10:5]} * {6'd0, weight_i};
    sum_b_d = {6'd0, 1'b0, fg_i[4:0]} * {6'd0, inv_w}
            + {6'd0, 1'b0, bg_i[4:0]} * {6'd0, weight_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en2) begin
      sum_r_q <= sum_r_d;
      sum_g_q <= sum_g_d;
      sum_b_q <= sum_b_d;
    end
  end

  always_comb begin
    q_r     = gcb_pkg::div63(sum_r_q);
    q_g     = gcb_pkg::div63(sum_g_q);
    q_b     = gcb_pkg::div63(sum_b_q);
    pixel_d = {q_r[4:0], q_g, q_b[4:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en3) begin
      pixel_q <= pixel_d;
    end
  end

  assign pixel_o = pixel_q;

endmodule

// ----- rtl/glyph_coverage_blend_core.sv -----
// ----------------------------------------------------------------------------
// glyph_coverage_blend_core: 4bpp glyph byte to two RGB565 pixels
// Blends foreground and background colors by nibble coverage.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one glyph byte per transfer, high nibble is the first pixel.
//   Output stream: one transfer per input byte carrying both blended pixels
//   in tdata and their write enables in tuser.
//   Colors and the opaque flag sit on an APB port (fg at 0x0, bg at 0x4,
//   opaque at 0x8); write them only while the pipeline is empty.
//   Stages: weight lookup, multiply-accumulate per channel, and divide-by-63
//   into the output register, whose valid flag drives m_axis_tvalid.
//   Throughput is one byte per cycle while the receiver takes every output;
//   each stage register takes a new item whenever it is empty or the stage
//   after it moves. When the receiver stalls, the output holds and the stages
//   behind it fill up; s_axis_tready drops only once all three stages hold an item.
//   Reset empties the pipeline and loads fg=0xFFFF, bg=0x0000, opaque=1.
// ----------------------------------------------------------------------------
module glyph_coverage_blend_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gcb_pkg::AddrW-1:0]   paddr,
  input  logic [gcb_pkg::DataW-1:0]   pwdata,
  output logic [gcb_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] coverage_pair
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,  // [15:0] pixel_first, [31:16] pixel_second
  output logic [1:0]                  m_axis_tuser   // [0] write_first, [1] write_second
);

  // configuration registers
  logic [gcb_pkg::ColorW-1:0] fg_q, fg_d;
  logic [gcb_pkg::ColorW-1:0] bg_q, bg_d;
  logic                       opaque_q, opaque_d;
  logic                       cfg_wr;
  logic [1:0]                 cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    fg_d     = fg_q;
    bg_d     = bg_q;
    opaque_d = opaque_q;
    if (cfg_wr) begin
      case (cfg_idx)
        gcb_pkg::RegFgColor: fg_d     = pwdata[gcb_pkg::ColorW-1:0];
        gcb_pkg::RegBgColor: bg_d     = pwdata[gcb_pkg::ColorW-1:0];
        gcb_pkg::RegOpaque:  opaque_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      gcb_pkg::RegFgColor: prdata = {16'd0, fg_q};
      gcb_pkg::RegBgColor: prdata = {16'd0, bg_q};
      gcb_pkg::RegOpaque:  prdata = {31'd0, opaque_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q     <= gcb_pkg::FgReset;
      bg_q     <= gcb_pkg::BgReset;
      opaque_q <= 1'b1;
    end else begin
      fg_q     <= fg_d;
      bg_q     <= bg_d;
      opaque_q <= opaque_d;
    end
  end

  // pipeline control: a stage loads when empty or when its successor moves
  logic v1_q, v2_q, v3_q;
  logic v1_d, v2_d, v3_d;
  logic rdy1, rdy2, rdy3;
  gcb_pkg::pipe_en_t pen;

  assign rdy3 = !v3_q || m_axis_tready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;
  assign pen.en2       = rdy2;
  assign pen.en3       = rdy3;

  assign v1_d = rdy1 ? s_axis_tvalid : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  // stage 1: weights and write enables
  logic [3:0]                  nib_hi, nib_lo;
  logic [gcb_pkg::WeightW-1:0] w_hi_q, w_lo_q;
  logic [1:0]                  wr1_d, wr1_q, wr2_q, wr3_q;

  assign nib_hi = s_axis_tdata[7:4];
  assign nib_lo = s_axis_tdata[3:0];
  assign wr1_d  = {opaque_q || (nib_lo != gcb_pkg::NibbleBg),
                   opaque_q || (nib_hi != gcb_pkg::NibbleBg)};

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      w_hi_q <= gcb_pkg::nibble_weight(nib_hi);
      w_lo_q <= gcb_pkg::nibble_weight(nib_lo);
      wr1_q  <= wr1_d;
    end
    if (rdy2) begin
      wr2_q <= wr1_q;
    end
    if (rdy3) begin
      wr3_q <= wr2_q;
    end
  end

  // stages 2 and 3: blend lanes
  logic [gcb_pkg::ColorW-1:0] pix_first, pix_second;

  gcb_pixel u_pix_first (
    .clk_i    (clk_i),
    .en_i     (pen),
    .weight_i (w_hi_q),
    .fg_i     (fg_q),
    .bg_i     (bg_q),
    .pixel_o  (pix_first)
  );

  gcb_pixel u_pix_second (
    .clk_i    (clk_i),
    .en_i     (pen),
    .weight_i (w_lo_q),
    .fg_i     (fg_q),
    .bg_i     (bg_q),
    .pixel_o  (pix_second)
  );

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {pix_second, pix_first};
  assign m_axis_tuser  = wr3_q;

  // assertions
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && v3_q))
    else $error("input blocked while a stage is empty");

  a_stage1_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && rdy2) |=> v2_q)
    else $error("item lost between stage 1 and stage 2");

  a_stage2_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && rdy3) |=> v3_q)
    else $error("item lost between stage 2 and the output");

endmodule
